@@ rtl/rgpp_pkg.sv @@
// ----------------------------------------------------------------------------
// rgpp_pkg: shared types, constants and the tangent table
// Widths of the range-grid projection datapath, register codes, the zone
// record passed from front to back, and the elaboration-time tan table.
// ----------------------------------------------------------------------------
package rgpp_pkg;

  localparam int MAX_ZONES_PER_AXIS = 8;
  localparam int POS_W              = 3;
  localparam int ZONE_W             = 4;
  localparam int ZONE_MIN           = 2;
  localparam int ZONE_LIMIT         = (MAX_ZONES_PER_AXIS < (1 << POS_W)) ?
                                      MAX_ZONES_PER_AXIS : (1 << POS_W);
  localparam int FOV_W              = 16;
  localparam int STEP_W             = 16;
  localparam int RANGE_W            = 16;
  localparam int COORD_W            = 18;
  localparam int SUM_W              = 18;
  localparam int CENTER_SHIFT       = 2;
  localparam int FRAC_BITS          = 14;
  localparam logic [FOV_W-1:0] FOV_LIMIT = FOV_W'(1 << (FRAC_BITS + 1));

  localparam int TAN_W              = 15;
  localparam int TAN_TABLE_DEPTH    = 1024;
  localparam int TAN_ABITS          = $clog2(TAN_TABLE_DEPTH);
  localparam int AMAG_W             = ZONE_W + STEP_W - 1;
  localparam int AIDX_WIDE_W        = AMAG_W + TAN_ABITS;
  localparam int PROD_W             = RANGE_W + TAN_W;
  localparam int PMAG_W             = PROD_W - FRAC_BITS;

  localparam int DIV_CNT_W          = $clog2(FOV_W);

  localparam int Q_DEPTH            = 4;
  localparam int Q_PTR_W            = $clog2(Q_DEPTH);
  localparam int Q_CNT_W            = $clog2(Q_DEPTH + 1);

  localparam int CFG_IDX_W          = 2;
  localparam int CFG_DATA_W         = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_H_ZONES = 2'd0,
    REG_V_ZONES = 2'd1,
    REG_H_FOV   = 2'd2,
    REG_V_FOV   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [ZONE_W-1:0] h_n;
    logic [ZONE_W-1:0] v_n;
    logic [STEP_W-1:0] h_step;
    logic [STEP_W-1:0] v_step;
  } grid_t;

  typedef struct packed {
    logic [TAN_ABITS-1:0] idx;
    logic                 flip;
  } axis_look_t;

  typedef struct packed {
    logic [RANGE_W-1:0] range_mm;
    logic [POS_W-1:0]   row;
    logic [POS_W-1:0]   col;
    logic               frame_end;
    logic [RANGE_W-1:0] center;
    axis_look_t         h;
    axis_look_t         v;
  } zone_desc_t;

  typedef logic [TAN_W-1:0] tan_rom_t [TAN_TABLE_DEPTH];
  typedef longint unsigned u64_t;

  function automatic logic [ZONE_W-1:0] eff_zones(logic [ZONE_W-1:0] v);
    logic [ZONE_W-1:0] r;
    r = v;
    if (r < ZONE_W'(ZONE_MIN)) r = ZONE_W'(ZONE_MIN);
    if (r > ZONE_W'(ZONE_LIMIT)) r = ZONE_W'(ZONE_LIMIT);
    return r;
  endfunction

  // restoring long division, only used while building the table
  function automatic u64_t udiv_u64(u64_t num, u64_t den);
    u64_t q;
    u64_t r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], num[i]};
      if (r >= den) begin
        r    = r - den;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // tan(k / depth) in Q1.14 from Q30 sin and cos series, rounded half up
  function automatic tan_rom_t build_tan_rom();
    tan_rom_t rom;
    u64_t     x;
    u64_t     x2;
    u64_t     term;
    u64_t     t;
    longint   s;
    longint   c;
    for (int k = 0; k < TAN_TABLE_DEPTH; k++) begin
      x  = (u64_t'(k) << 30) / TAN_TABLE_DEPTH;
      x2 = (x * x) >> 30;
      term = x;
      s = longint'(x);
      c = longint'(u64_t'(1) << 30);
      for (int n = 1; n <= 8; n++) begin
        term = udiv_u64((term * x2) >> 30, u64_t'((2 * n) * (2 * n + 1)));
        s = (n % 2 == 1) ? s - longint'(term) : s + longint'(term);
      end
      term = u64_t'(1) << 30;
      for (int n = 1; n <= 8; n++) begin
        term = udiv_u64((term * x2) >> 30, u64_t'((2 * n - 1) * (2 * n)));
        c = (n % 2 == 1) ? c - longint'(term) : c + longint'(term);
      end
      if (s < 0) s = 0;
      if (c < 1) c = 1;
      t = udiv_u64((u64_t'(s) << FRAC_BITS) + (u64_t'(c) >> 1), u64_t'(c));
      if (t > u64_t'((1 << TAN_W) - 1)) t = u64_t'((1 << TAN_W) - 1);
      rom[k] = TAN_W'(t);
    end
    return rom;
  endfunction

endpackage

@@ rtl/rgpp_if.sv @@
// ----------------------------------------------------------------------------
// rgpp_if: channel interfaces
// Zone item input, point result output and register write channels.
// ----------------------------------------------------------------------------
interface rgpp_item_if import rgpp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [RANGE_W-1:0] range_mm;
  logic               frame_start;

  modport source (output valid, output range_mm, output frame_start, input ready);
  modport sink   (input valid, input range_mm, input frame_start, output ready);
endinterface

interface rgpp_point_if import rgpp_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [RANGE_W-1:0]        point_x;
  logic signed [COORD_W-1:0] point_y;
  logic signed [COORD_W-1:0] point_z;
  logic [POS_W-1:0]          zone_row;
  logic [POS_W-1:0]          zone_col;
  logic                      frame_end;
  logic [RANGE_W-1:0]        center_range_mm;

  modport source (output valid, output point_x, output point_y, output point_z,
                  output zone_row, output zone_col, output frame_end,
                  output center_range_mm, input ready);
  modport sink   (input valid, input point_x, input point_y, input point_z,
                  input zone_row, input zone_col, input frame_end,
                  input center_range_mm, output ready);
endinterface

interface rgpp_cfg_if import rgpp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/rgpp_step_div.sv @@
// ----------------------------------------------------------------------------
// rgpp_step_div: angular step divider
// Radix-2 restoring division of both fields of view by their zone counts,
// one quotient bit per axis each cycle.
// ----------------------------------------------------------------------------
module rgpp_step_div import rgpp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [FOV_W-1:0]  h_fov,
  input  logic [FOV_W-1:0]  v_fov,
  input  logic [ZONE_W-1:0] h_n,
  input  logic [ZONE_W-1:0] v_n,
  output logic              busy,
  output logic [STEP_W-1:0] h_step,
  output logic [STEP_W-1:0] v_step
);

  logic [DIV_CNT_W-1:0] cnt;
  logic [ZONE_W-1:0]    h_div, v_div, h_rem, v_rem, h_rem_next, v_rem_next;
  logic [FOV_W-1:0]     h_dvd, v_dvd, h_dvd_next, v_dvd_next;
  logic [ZONE_W:0]      h_wide, v_wide;
  logic                 h_ge, v_ge;

  always_comb begin
    h_wide     = {h_rem, h_dvd[FOV_W-1]};
    v_wide     = {v_rem, v_dvd[FOV_W-1]};
    h_ge       = h_wide >= {1'b0, h_div};
    v_ge       = v_wide >= {1'b0, v_div};
    h_rem_next = h_ge ? ZONE_W'(h_wide - {1'b0, h_div}) : ZONE_W'(h_wide);
    v_rem_next = v_ge ? ZONE_W'(v_wide - {1'b0, v_div}) : ZONE_W'(v_wide);
    h_dvd_next = {h_dvd[FOV_W-2:0], h_ge};
    v_dvd_next = {v_dvd[FOV_W-2:0], v_ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '1;
    end else if (busy) begin
      cnt <= cnt - DIV_CNT_W'(1);
      if (cnt == '0) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      h_dvd <= h_fov;
      v_dvd <= v_fov;
      h_div <= h_n;
      v_div <= v_n;
      h_rem <= '0;
      v_rem <= '0;
    end else if (busy) begin
      h_dvd <= h_dvd_next;
      v_dvd <= v_dvd_next;
      h_rem <= h_rem_next;
      v_rem <= v_rem_next;
    end
  end

  assign h_step = STEP_W'(h_dvd);
  assign v_step = STEP_W'(v_dvd);

endmodule

@@ rtl/rgpp_front.sv @@
// ----------------------------------------------------------------------------
// rgpp_front: zone sequencer
// Tracks grid position and center sum, derives each zone's tan table index
// and sign, and pushes a zone record into the queue.
// ----------------------------------------------------------------------------
module rgpp_front import rgpp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  rgpp_item_if.sink  item,
  input  grid_t      grid,
  input  logic       step_ok,
  input  logic       q_full,
  output logic       q_push,
  output zone_desc_t q_data
);

  logic [POS_W-1:0]  col_position, row_position, col_next, row_next;
  logic [SUM_W-1:0]  center_sum, center_sum_next, sum_cur, sum_add;
  logic [ZONE_W-1:0] col_cur, row_cur, col_inc, row_inc;
  logic [ZONE_W-1:0] h_center, v_center;
  logic              in_center, last;

  function automatic axis_look_t axis_look(logic [ZONE_W-1:0] pos,
                                           logic [ZONE_W-1:0] n,
                                           logic [STEP_W-1:0] step);
    logic signed [ZONE_W+1:0]   d;
    logic [ZONE_W-1:0]          ad;
    logic [ZONE_W+STEP_W-1:0]   prod;
    logic [AMAG_W-1:0]          mag;
    logic [AIDX_WIDE_W-1:0]     wide;
    axis_look_t                 r;
    d    = $signed({1'b0, pos, 1'b0}) - $signed({2'b00, n}) + $signed((ZONE_W+2)'(1));
    ad   = d[ZONE_W+1] ? ZONE_W'(-d) : ZONE_W'(d);
    prod = (ZONE_W+STEP_W)'(ad) * (ZONE_W+STEP_W)'(step);
    mag  = prod[ZONE_W+STEP_W-1:1];
    wide = {mag, {TAN_ABITS{1'b0}}} >> FRAC_BITS;
    r.idx  = (|wide[AIDX_WIDE_W-1:TAN_ABITS]) ? '1 : wide[TAN_ABITS-1:0];
    r.flip = (d > 0);
    return r;
  endfunction

  assign item.ready = step_ok && !q_full;
  assign q_push     = item.valid && item.ready;

  always_comb begin
    col_cur = item.frame_start ? '0 : ZONE_W'(col_position);
    row_cur = item.frame_start ? '0 : ZONE_W'(row_position);
    sum_cur = item.frame_start ? '0 : center_sum;
    if (col_cur >= grid.h_n) col_cur = '0;
    if (row_cur >= grid.v_n) row_cur = '0;

    h_center  = (grid.h_n >> 1) - ZONE_W'(1);
    v_center  = (grid.v_n >> 1) - ZONE_W'(1);
    in_center = (row_cur == v_center || row_cur == v_center + ZONE_W'(1)) &&
                (col_cur == h_center || col_cur == h_center + ZONE_W'(1));
    sum_add   = in_center ? sum_cur + SUM_W'(item.range_mm) : sum_cur;
    last      = (col_cur == grid.h_n - ZONE_W'(1)) && (row_cur == grid.v_n - ZONE_W'(1));

    col_inc         = col_cur + ZONE_W'(1);
    row_inc         = row_cur;
    center_sum_next = sum_add;
    if (col_inc >= grid.h_n) begin
      col_inc = '0;
      row_inc = row_cur + ZONE_W'(1);
      if (row_inc >= grid.v_n) begin
        row_inc         = '0;
        center_sum_next = '0;
      end
    end
    col_next = POS_W'(col_inc);
    row_next = POS_W'(row_inc);

    q_data.range_mm  = item.range_mm;
    q_data.row       = POS_W'(row_cur);
    q_data.col       = POS_W'(col_cur);
    q_data.frame_end = last;
    q_data.center    = last ? RANGE_W'(sum_add >> CENTER_SHIFT) : '0;
    q_data.h         = axis_look(col_cur, grid.h_n, grid.h_step);
    q_data.v         = axis_look(row_cur, grid.v_n, grid.v_step);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_position <= '0;
      row_position <= '0;
      center_sum   <= '0;
    end else if (q_push) begin
      col_position <= col_next;
      row_position <= row_next;
      center_sum   <= center_sum_next;
    end
  end

endmodule

@@ rtl/rgpp_fifo.sv @@
// ----------------------------------------------------------------------------
// rgpp_fifo: zone record queue
// Short register queue between the sequencer and the projection unit.
// ----------------------------------------------------------------------------
module rgpp_fifo import rgpp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  zone_desc_t wr_data,
  input  logic       pop,
  output zone_desc_t rd_data,
  output logic       full,
  output logic       empty
);

  zone_desc_t          slots [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [Q_CNT_W-1:0]  count;

  assign full    = (count == Q_CNT_W'(Q_DEPTH));
  assign empty   = (count == '0);
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + Q_PTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + Q_PTR_W'(1);
      unique case ({push, pop})
        2'b10:   count <= count + Q_CNT_W'(1);
        2'b01:   count <= count - Q_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= Q_CNT_W'(Q_DEPTH))
    else $error("queue count past depth");
  assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("pop from empty queue");

endmodule

@@ rtl/rgpp_back.sv @@
// ----------------------------------------------------------------------------
// rgpp_back: point projection unit
// Reads tan for both axes through one table port, scales the range with one
// shared multiplier, and holds the finished point in an output register.
// ----------------------------------------------------------------------------
module rgpp_back import rgpp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         q_empty,
  input  zone_desc_t   q_data,
  output logic         q_pop,
  rgpp_point_if.source point
);

  localparam tan_rom_t TAN_ROM = build_tan_rom();

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_TAN_H = 5'b00010,
    S_TAN_V = 5'b00100,
    S_MUL_V = 5'b01000,
    S_FIN   = 5'b10000
  } state_t;

  state_t               state, state_next;
  zone_desc_t           desc;
  logic [TAN_ABITS-1:0] rom_addr;
  logic [TAN_W-1:0]     rom_q;
  logic [PROD_W-1:0]    prod_h, prod_v, prod;
  logic                 out_free, out_load;

  function automatic logic [COORD_W-1:0] to_coord(logic [PROD_W-1:0] p, logic flip);
    logic [PMAG_W-1:0] mag;
    int                e;
    mag = p[PROD_W-1:FRAC_BITS];
    e   = flip ? -int'(mag) : int'(mag);
    if (e > (1 << (COORD_W - 1)) - 1) e = (1 << (COORD_W - 1)) - 1;
    if (e < -(1 << (COORD_W - 1)))    e = -(1 << (COORD_W - 1));
    return COORD_W'(e);
  endfunction

  assign out_free = !point.valid || point.ready;
  assign q_pop    = (state == S_IDLE) && !q_empty;
  assign out_load = (state == S_FIN) && out_free;
  assign rom_addr = (state == S_TAN_V) ? desc.v.idx : desc.h.idx;
  assign prod     = PROD_W'(desc.range_mm) * PROD_W'(rom_q);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (!q_empty) state_next = S_TAN_H;
      S_TAN_H: state_next = S_TAN_V;
      S_TAN_V: state_next = S_MUL_V;
      S_MUL_V: state_next = S_FIN;
      S_FIN:   if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      point.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        point.valid <= 1'b1;
      end else if (point.ready) begin
        point.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rom_q <= TAN_ROM[rom_addr];
    if (q_pop) desc <= q_data;
    if (state == S_TAN_V) prod_h <= prod;
    if (state == S_MUL_V) prod_v <= prod;
    if (out_load) begin
      point.point_x         <= desc.range_mm;
      point.point_y         <= to_coord(prod_h, desc.h.flip);
      point.point_z         <= to_coord(prod_v, desc.v.flip);
      point.zone_row        <= desc.row;
      point.zone_col        <= desc.col;
      point.frame_end       <= desc.frame_end;
      point.center_range_mm <= desc.center;
    end
  end

  assert property (@(posedge clk) disable iff (rst) $rose(point.valid) |-> $past(state == S_FIN))
    else $error("result shown outside final step");
  assert property (@(posedge clk) disable iff (rst)
                   (point.valid && !point.ready) |=> point.valid)
    else $error("pending result dropped");

endmodule

@@ rtl/range_grid_to_point_projection.sv @@
// ----------------------------------------------------------------------------
// range_grid_to_point_projection: zone ranges to 3-D points
//
//   channel  dir  handshake      payload
//   item     in   valid/ready    range_mm, frame_start
//   point    out  valid/ready    point_x/y/z, zone_row/col, frame_end, center
//   cfg      in   valid/ready    index, data (ready always high)
//
// The sequencer takes one item per cycle into a 4-entry queue while the queue
// has room and no step recalculation is pending; the projection unit walks
// idle, tan-h, tan-v, multiply and finish states per point, set by the single
// tan table port and the single multiplier shared by y and z. After reset and
// each register write the step divider runs again; item ready is low until done.
// Reset clears position, center sum, queue, divider and output valid.
// A stalled point output holds; one more point is finished behind it.
// ----------------------------------------------------------------------------
module range_grid_to_point_projection import rgpp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  rgpp_item_if.sink    item,
  rgpp_point_if.source point,
  rgpp_cfg_if.sink     cfg
);

  logic [ZONE_W-1:0] horizontal_zones, vertical_zones;
  logic [FOV_W-1:0]  h_fov_cfg, v_fov_cfg, h_fov, v_fov;
  logic              recalc, div_busy, div_start;
  grid_t             grid;
  logic              q_push, q_pop, q_full, q_empty;
  zone_desc_t        q_wr, q_rd;

  assign cfg.ready = 1'b1;
  assign h_fov     = (h_fov_cfg > FOV_LIMIT) ? FOV_LIMIT : h_fov_cfg;
  assign v_fov     = (v_fov_cfg > FOV_LIMIT) ? FOV_LIMIT : v_fov_cfg;
  assign grid.h_n  = eff_zones(horizontal_zones);
  assign grid.v_n  = eff_zones(vertical_zones);
  assign div_start = recalc && !div_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      horizontal_zones <= ZONE_W'(8);
      vertical_zones   <= ZONE_W'(8);
      h_fov_cfg        <= FOV_W'(12868);
      v_fov_cfg        <= FOV_W'(12868);
      recalc           <= 1'b1;
    end else if (cfg.valid && cfg.ready) begin
      recalc <= 1'b1;
      unique case (cfg_reg_t'(cfg.index))
        REG_H_ZONES: horizontal_zones <= cfg.data[ZONE_W-1:0];
        REG_V_ZONES: vertical_zones   <= cfg.data[ZONE_W-1:0];
        REG_H_FOV:   h_fov_cfg        <= cfg.data[FOV_W-1:0];
        REG_V_FOV:   v_fov_cfg        <= cfg.data[FOV_W-1:0];
        default:     ;
      endcase
    end else if (div_start) begin
      recalc <= 1'b0;
    end
  end

  rgpp_step_div u_step_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .h_fov  (h_fov),
    .v_fov  (v_fov),
    .h_n    (grid.h_n),
    .v_n    (grid.v_n),
    .busy   (div_busy),
    .h_step (grid.h_step),
    .v_step (grid.v_step)
  );

  rgpp_front u_front (
    .clk     (clk),
    .rst     (rst),
    .item    (item),
    .grid    (grid),
    .step_ok (!recalc && !div_busy),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_wr)
  );

  rgpp_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (q_wr),
    .pop     (q_pop),
    .rd_data (q_rd),
    .full    (q_full),
    .empty   (q_empty)
  );

  rgpp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (q_rd),
    .q_pop   (q_pop),
    .point   (point)
  );

  assert property (@(posedge clk) disable iff (rst)
                   (item.valid && item.ready) |-> (!recalc && !div_busy))
    else $error("item transfer while steps are stale");
  assert property (@(posedge clk) disable iff (rst)
                   (point.valid && !point.frame_end) |-> (point.center_range_mm == '0))
    else $error("center range outside frame end");

endmodule

@@ tb/range_grid_to_point_projection_tb.sv @@
// ----------------------------------------------------------------------------
// range_grid_to_point_projection_tb: zone range to point projection check
// Streams zone ranges over several grid and field-of-view settings, mirrors
// position, center sum and the tan lookup in a scoreboard, and checks every
// point field in order. Both channels stall at random, and a long output
// stall backs the block up into its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module range_grid_to_point_projection_tb import rgpp_pkg::*; ();

  localparam int TAN_ENTRIES = 1024;
  localparam int MAX_ZONES   = 8;
  localparam int FOV_CLAMP   = 32768;
  localparam int Y_MAX       = 131071;
  localparam int Y_MIN       = -131072;
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 150;

  typedef longint unsigned wide_t;

  typedef struct {
    logic [RANGE_W-1:0]        x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [POS_W-1:0]          row;
    logic [POS_W-1:0]          col;
    logic                      last;
    logic [RANGE_W-1:0]        center;
  } zone_point_t;

  function automatic int clamp_zones(logic [ZONE_W-1:0] v);
    int n;
    n = v;
    if (n < 2) n = 2;
    if (n > MAX_ZONES) n = MAX_ZONES;
    return n;
  endfunction

  class zone_projector;
    logic [14:0]       tan_q14 [TAN_ENTRIES];
    logic [ZONE_W-1:0] h_zones;
    logic [ZONE_W-1:0] v_zones;
    logic [FOV_W-1:0]  h_fov;
    logic [FOV_W-1:0]  v_fov;
    int                col;
    int                row;
    logic [SUM_W-1:0]  center_sum;
    zone_point_t       pending_points [$];
    int                failures;

    function new();
      wide_t  x;
      wide_t  x2;
      wide_t  term;
      wide_t  t;
      longint s;
      longint c;
      for (int k = 0; k < TAN_ENTRIES; k++) begin
        x = (wide_t'(k) << 30) / TAN_ENTRIES;
        x2 = (x * x) >> 30;
        term = x;
        s = longint'(x);
        c = longint'(wide_t'(1) << 30);
        for (int n = 1; n <= 8; n++) begin
          term = ((term * x2) >> 30) / wide_t'((2 * n) * (2 * n + 1));
          if (n % 2 == 1) s = s - longint'(term);
          else s = s + longint'(term);
        end
        term = wide_t'(1) << 30;
        for (int n = 1; n <= 8; n++) begin
          term = ((term * x2) >> 30) / wide_t'((2 * n - 1) * (2 * n));
          if (n % 2 == 1) c = c - longint'(term);
          else c = c + longint'(term);
        end
        if (s < 0) s = 0;
        if (c < 1) c = 1;
        t = ((wide_t'(s) << 14) + (wide_t'(c) >> 1)) / wide_t'(c);
        if (t > 32767) t = 32767;
        tan_q14[k] = t[14:0];
      end
      h_zones = 4'd8;
      v_zones = 4'd8;
      h_fov = 16'd12868;
      v_fov = 16'd12868;
      col = 0;
      row = 0;
      center_sum = '0;
      failures = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        REG_H_ZONES: h_zones = d[ZONE_W-1:0];
        REG_V_ZONES: v_zones = d[ZONE_W-1:0];
        REG_H_FOV:   h_fov = d[FOV_W-1:0];
        REG_V_FOV:   v_fov = d[FOV_W-1:0];
        default: ;
      endcase
    endfunction

    // signed Q2.14 angle of zone idx on an n-zone axis
    function int zone_angle(int idx, int n, int step);
      int d;
      int mag;
      d = 2 * idx - (n - 1);
      mag = ((d < 0 ? -d : d) * step) >> 1;
      return d < 0 ? -mag : mag;
    endfunction

    function logic signed [COORD_W-1:0] project_axis(logic [RANGE_W-1:0] mm, int angle);
      int     mag;
      int     idx;
      longint p;
      mag = angle < 0 ? -angle : angle;
      idx = (mag * TAN_ENTRIES) >> 14;
      if (idx >= TAN_ENTRIES) idx = TAN_ENTRIES - 1;
      p = (longint'(mm) * longint'(tan_q14[idx])) >> 14;
      if (angle > 0) p = -p;
      if (p > Y_MAX) p = Y_MAX;
      if (p < Y_MIN) p = Y_MIN;
      return p[COORD_W-1:0];
    endfunction

    function void take_zone(logic [RANGE_W-1:0] mm, logic start);
      int          nh;
      int          nv;
      int          hf;
      int          vf;
      int          ch;
      int          cv;
      logic        last;
      zone_point_t p;
      nh = clamp_zones(h_zones);
      nv = clamp_zones(v_zones);
      hf = (h_fov > FOV_CLAMP) ? FOV_CLAMP : int'(h_fov);
      vf = (v_fov > FOV_CLAMP) ? FOV_CLAMP : int'(v_fov);
      ch = nh / 2 - 1;
      cv = nv / 2 - 1;
      if (start) begin
        col = 0;
        row = 0;
        center_sum = '0;
      end
      if (col >= nh) col = 0;
      if (row >= nv) row = 0;
      if ((row == cv || row == cv + 1) && (col == ch || col == ch + 1))
        center_sum = center_sum + SUM_W'(mm);
      last = (col == nh - 1) && (row == nv - 1);
      p.x = mm;
      p.y = project_axis(mm, zone_angle(col, nh, hf / nh));
      p.z = project_axis(mm, zone_angle(row, nv, vf / nv));
      p.row = POS_W'(row);
      p.col = POS_W'(col);
      p.last = last;
      p.center = last ? center_sum[RANGE_W+1:2] : '0;
      pending_points.push_back(p);
      col++;
      if (col >= nh) begin
        col = 0;
        row++;
        if (row >= nv) begin
          row = 0;
          center_sum = '0;
        end
      end
    endfunction

    function void check_point(zone_point_t got);
      zone_point_t e;
      if (pending_points.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected point x=%0d row=%0d col=%0d", got.x, got.row, got.col);
        return;
      end
      e = pending_points.pop_front();
      if (got.x !== e.x || got.y !== e.y || got.z !== e.z || got.row !== e.row ||
          got.col !== e.col || got.last !== e.last || got.center !== e.center) begin
        failures++;
        if (failures <= 10) begin
          $display("point mismatch: got x=%0d y=%0d z=%0d row=%0d col=%0d end=%0b ctr=%0d",
                   got.x, got.y, got.z, got.row, got.col, got.last, got.center);
          $display("            expected x=%0d y=%0d z=%0d row=%0d col=%0d end=%0b ctr=%0d",
                   e.x, e.y, e.z, e.row, e.col, e.last, e.center);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  rgpp_item_if  zone_ch ();
  rgpp_point_if point_ch ();
  rgpp_cfg_if   reg_ch ();

  range_grid_to_point_projection u_top (
    .clk   (clk),
    .rst   (rst),
    .item  (zone_ch),
    .point (point_ch),
    .cfg   (reg_ch)
  );

  zone_projector proj = new();

  int src_idle_pct = 9;
  int snk_idle_pct = 70;
  int points_done  = 0;
  int idle_cycles  = 0;
  int hold_left    = 0;
  bit pressure_done = 1'b0;

  always #5 clk = ~clk;

  always @(posedge clk) begin
    zone_point_t got;
    if (!rst) begin
      if (zone_ch.valid && zone_ch.ready)
        proj.take_zone(zone_ch.range_mm, zone_ch.frame_start);
      if (reg_ch.valid && reg_ch.ready)
        proj.write_reg(cfg_reg_t'(reg_ch.index), reg_ch.data);
      if (point_ch.valid && point_ch.ready) begin
        got.x = point_ch.point_x;
        got.y = point_ch.point_y;
        got.z = point_ch.point_z;
        got.row = point_ch.zone_row;
        got.col = point_ch.zone_col;
        got.last = point_ch.frame_end;
        got.center = point_ch.center_range_mm;
        proj.check_point(got);
        points_done++;
      end
      if ((zone_ch.valid && zone_ch.ready) || (reg_ch.valid && reg_ch.ready) ||
          (point_ch.valid && point_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= QUIET_LIMIT) begin
        $display("range_grid_to_point_projection_tb NOT OK");
        $finish;
      end
    end
  end

  // point receiver, with one long hold-off to back up the block
  initial begin
    point_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!pressure_done && points_done >= 60) begin
        pressure_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        point_ch.ready <= 1'b0;
      end else begin
        point_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  task automatic send_zone(logic [RANGE_W-1:0] mm, logic start);
    while ($urandom_range(99) < src_idle_pct) begin
      zone_ch.valid <= 1'b0;
      @(negedge clk);
    end
    zone_ch.valid <= 1'b1;
    zone_ch.range_mm <= mm;
    zone_ch.frame_start <= start;
    do @(posedge clk); while (!zone_ch.ready);
    @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] d);
    reg_ch.valid <= 1'b1;
    reg_ch.index <= idx;
    reg_ch.data <= d;
    do @(posedge clk); while (!reg_ch.ready);
    @(negedge clk);
  endtask

  task automatic drain_points();
    zone_ch.valid <= 1'b0;
    while (proj.pending_points.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic program_grid(logic [ZONE_W-1:0] hn, logic [ZONE_W-1:0] vn,
                              logic [FOV_W-1:0] hf, logic [FOV_W-1:0] vf);
    drain_points();
    write_reg(REG_H_ZONES, CFG_DATA_W'(hn));
    write_reg(REG_V_ZONES, CFG_DATA_W'(vn));
    write_reg(REG_H_FOV, hf);
    write_reg(REG_V_FOV, vf);
    reg_ch.valid <= 1'b0;
  endtask

  initial begin
    int                 r;
    int                 frame_pos;
    int                 frame_len;
    logic [RANGE_W-1:0] mm;
    logic               start;
    logic [ZONE_W-1:0]  hn;
    logic [ZONE_W-1:0]  vn;
    logic [FOV_W-1:0]   hf;
    logic [FOV_W-1:0]   vf;

    zone_ch.valid = 1'b0;
    zone_ch.range_mm = '0;
    zone_ch.frame_start = 1'b0;
    reg_ch.valid = 1'b0;
    reg_ch.index = REG_H_ZONES;
    reg_ch.data = '0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // reset grid, then shrink it mid-row so the column wraps
    send_zone(16'h0000, 1'b1);
    send_zone(16'hFFFF, 1'b0);
    send_zone(16'h5555, 1'b0);
    send_zone(16'hAAAA, 1'b0);
    program_grid(4'd3, 4'd3, 16'hFFFF, 16'h0000);
    repeat (9) send_zone(16'hFFFF, 1'b0);
    send_zone(16'h8001, 1'b0);
    send_zone(16'h7FFE, 1'b0);
    send_zone(16'h00FF, 1'b1);
    // smallest grid at widest field of view, frame start mid-frame
    program_grid(4'd2, 4'd2, 16'd32768, 16'd32768);
    repeat (4) send_zone(16'hFFFF, 1'b0);
    send_zone(16'h0001, 1'b0);
    send_zone(16'h0002, 1'b1);

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin hn = 4'd8;  vn = 4'd8;  hf = 16'd32768; vf = 16'd32768; end
        1: begin hn = 4'd0;  vn = 4'd15; hf = 16'hFFFF;  vf = 16'd12868; end
        2: begin hn = 4'd15; vn = 4'd2;  hf = 16'd0;     vf = 16'd40000; end
        default: begin
          hn = 4'($urandom_range(15));
          vn = 4'($urandom_range(15));
          hf = $urandom_range(1) ? 16'($urandom_range(65535)) : 16'($urandom_range(32768));
          vf = $urandom_range(1) ? 16'($urandom_range(65535)) : 16'($urandom_range(32768));
        end
      endcase
      if (phase == 2) begin
        src_idle_pct = 70;
        snk_idle_pct = 9;
      end else if (phase == 4) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      program_grid(hn, vn, hf, vf);
      frame_len = clamp_zones(hn) * clamp_zones(vn);
      frame_pos = 0;
      for (int i = 0; i < 64; i++) begin
        if (frame_pos >= frame_len) frame_pos = 0;
        r = $urandom_range(99);
        start = (frame_pos == 0) ? (r < 90) : (r < 3);
        if (start) frame_pos = 0;
        r = $urandom_range(9);
        mm = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : 16'($urandom);
        send_zone(mm, start);
        frame_pos++;
      end
    end

    drain_points();
    repeat (20) @(negedge clk);
    if (proj.failures == 0 && proj.pending_points.size() == 0) begin
      $display("range_grid_to_point_projection_tb OK");
    end else begin
      $display("range_grid_to_point_projection_tb NOT OK");
    end
    $finish;
  end

endmodule
